// ===== src/assert_macros.svh =====
// assertion macros used by the gini split search
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define GSS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gini split search assertion failed");
// condition must never be true out of reset
`define GSS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("gini split search forbidden condition");
`else
`define GSS_ASSERT(lbl, clk, rst_n, prop)
`define GSS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/gss_pkg.sv =====
// shared constants and types of the gini split search
`timescale 1ns / 1ps
package gss_pkg;
    // default sizes
    localparam int MAX_SAMPLES_DEF  = 1024;
    localparam int MAX_FEATURES_DEF = 16;
    localparam int MAX_CLASSES_DEF  = 16;
    localparam int VALUE_WIDTH_DEF  = 32;

    // fixed point
    localparam int FRAC_BITS = 16;

    // configuration port
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT   = 1'd1;
    localparam logic [CFG_W-1:0] FEATURE_COUNT_RST = 5'd1;
    localparam logic [CFG_W-1:0] CLASS_COUNT_RST   = 5'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_PARTIAL = 2'd2;
    localparam logic [1:0] STATUS_DROPPED = 2'd3;

    // sequencer states
    typedef enum logic [3:0] {
        S_LOAD,
        S_THR_RD,
        S_THR_CAP,
        S_SWEEP,
        S_DRAIN,
        S_EV_LOAD,
        S_EV_MUL,
        S_DIVL_GO,
        S_DIVL_WAIT,
        S_DIVR_GO,
        S_DIVR_WAIT,
        S_EV_NEXT,
        S_CMP,
        S_OUT
    } t_state;

    // token passed along the class cell chain
    typedef struct packed {
        logic valid;
        logic right;
    } t_tok;
endpackage

// ===== src/gss_if.sv =====
// stream interfaces for sample items and split results
`timescale 1ns / 1ps
interface gss_in_if #(
    parameter int VW = gss_pkg::VALUE_WIDTH_DEF,
    parameter int LW = 4
);
    logic          valid;
    logic          ready;
    logic [VW-1:0] feature_value;
    logic [LW-1:0] class_label;
    logic          last_item;
    modport source (output valid, feature_value, class_label, last_item, input ready);
    modport sink (input valid, feature_value, class_label, last_item, output ready);
endinterface

interface gss_out_if #(
    parameter int VW = gss_pkg::VALUE_WIDTH_DEF,
    parameter int FW = 4,
    parameter int IW = 27,
    parameter int CW = 11
);
    logic          valid;
    logic          ready;
    logic [FW-1:0] best_feature;
    logic [VW-1:0] best_threshold;
    logic [IW-1:0] best_impurity;
    logic [CW-1:0] sample_total;
    logic [1:0]    status;
    modport source (output valid, best_feature, best_threshold, best_impurity,
                    sample_total, status, input ready);
    modport sink (input valid, best_feature, best_threshold, best_impurity,
                  sample_total, status, output ready);
endinterface

// ===== src/gss_cell.sv =====
// one class counter cell of the chain
`timescale 1ns / 1ps
module gss_cell #(
    parameter int CLASS_ID = 0,
    parameter int LW = 4,
    parameter int CW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_shift,
    input  gss_pkg::t_tok i_tok,
    input  logic [LW-1:0] i_tok_label,
    output gss_pkg::t_tok o_tok,
    output logic [LW-1:0] o_tok_label,
    input  logic [CW-1:0] i_next_left,
    input  logic [CW-1:0] i_next_right,
    output logic [CW-1:0] o_left,
    output logic [CW-1:0] o_right
);
    gss_pkg::t_tok r_tok;
    logic [LW-1:0] r_tok_label;
    logic [CW-1:0] r_left;
    logic [CW-1:0] r_right;

    // count matching tokens, or shift counts toward cell zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else begin
            r_tok <= i_tok;
            if (i_shift) begin
                r_left  <= i_next_left;
                r_right <= i_next_right;
            end else if (i_tok.valid && i_en && i_tok_label == LW'(CLASS_ID)) begin
                if (i_tok.right) begin
                    r_right <= r_right + 1'b1;
                end else begin
                    r_left <= r_left + 1'b1;
                end
            end
        end
    end

    // label travels with the token
    always_ff @(posedge i_clk) begin
        r_tok_label <= i_tok_label;
    end

    assign o_tok       = r_tok;
    assign o_tok_label = r_tok_label;
    assign o_left      = r_left;
    assign o_right     = r_right;
endmodule

// ===== src/gss_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module gss_div #(
    parameter int NW = 38,
    parameter int DW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int KW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_cnt;
    logic [DW:0]   r_rem;
    logic [NW-1:0] r_quot;
    logic [DW-1:0] r_den;
    logic [DW:0]   rem_sh;

    assign rem_sh = {r_rem[DW-1:0], r_quot[NW-1]};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem  <= rem_sh - {1'b0, r_den};
                r_quot <= {r_quot[NW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_quot <= {r_quot[NW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== src/gini_split_search.sv =====
// gini split search: loads up to MAX_SAMPLES samples, then finds the best split.
// loading: one item per cycle; the last item starts the search, loading resumes after the transfer.
// search: nf * n candidates, each with threshold read, sweep, drain and compare, plus per class
// a left and a right division on the shared bit-serial divider, each skipped for a side without samples;
// an empty set is valid in the cycle after its last item.
// reset is synchronous active low: counters, cells and state clear, stores stay as written.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gini_split_search #(
    parameter int MAX_SAMPLES  = gss_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_FEATURES = gss_pkg::MAX_FEATURES_DEF,
    parameter int MAX_CLASSES  = gss_pkg::MAX_CLASSES_DEF,
    parameter int VALUE_WIDTH  = gss_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gss_pkg::CFG_W-1:0]     i_cfg_data,
    gss_in_if.sink                        i_in,
    gss_out_if.source                     o_out
);
    localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int NFW = $clog2(MAX_FEATURES + 1);
    localparam int LW  = $clog2(MAX_CLASSES);
    localparam int NCW = $clog2(MAX_CLASSES + 1);
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SIW = $clog2(MAX_SAMPLES);
    localparam int AW  = $clog2(MAX_SAMPLES * MAX_FEATURES);
    localparam int IW  = CW + gss_pkg::FRAC_BITS;
    localparam int NW  = 2 * CW + gss_pkg::FRAC_BITS;
    localparam int DRW = $clog2(MAX_CLASSES + 2);
    localparam int VW  = VALUE_WIDTH;

    // configuration registers
    logic [gss_pkg::CFG_W-1:0] r_feature_count;
    logic [gss_pkg::CFG_W-1:0] r_class_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_count <= gss_pkg::FEATURE_COUNT_RST;
            r_class_count   <= gss_pkg::CLASS_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gss_pkg::CFG_FEATURE_COUNT: r_feature_count <= i_cfg_data;
                gss_pkg::CFG_CLASS_COUNT:   r_class_count   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective feature and class counts
    logic [NFW-1:0] nf_eff;
    logic [NCW-1:0] nc_eff;

    always_comb begin
        if (r_feature_count == '0) begin
            nf_eff = NFW'(1);
        end else if (int'(r_feature_count) > MAX_FEATURES) begin
            nf_eff = NFW'(MAX_FEATURES);
        end else begin
            nf_eff = NFW'(r_feature_count);
        end
        if (int'(r_class_count) > MAX_CLASSES) begin
            nc_eff = NCW'(MAX_CLASSES);
        end else begin
            nc_eff = NCW'(r_class_count);
        end
    end

    gss_pkg::t_state r_state, n_state;

    // loader state
    logic [CW-1:0] r_sample_cnt, n_sample_cnt;
    logic [FW-1:0] r_pos, n_pos;
    logic          r_dropped, n_dropped;
    logic [FW:0]   pos_inc;
    logic          full;
    logic          in_accept;
    logic          in_ready;
    logic          out_valid;
    logic          out_xfer;
    logic [1:0]    n_status;

    assign full      = (r_sample_cnt == CW'(MAX_SAMPLES));
    assign in_accept = i_in.valid && in_ready;
    assign out_xfer  = out_valid && o_out.ready;
    assign pos_inc   = {1'b0, r_pos} + 1'b1;

    always_comb begin
        n_sample_cnt = r_sample_cnt;
        n_pos        = r_pos;
        n_dropped    = r_dropped;
        if (full) begin
            n_dropped = 1'b1;
        end else if (int'(pos_inc) >= int'(nf_eff)) begin
            n_pos        = '0;
            n_sample_cnt = r_sample_cnt + 1'b1;
        end else begin
            n_pos = pos_inc[FW-1:0];
        end
        if (n_sample_cnt == '0) begin
            n_status = gss_pkg::STATUS_EMPTY;
        end else if (n_dropped) begin
            n_status = gss_pkg::STATUS_DROPPED;
        end else if (n_pos != '0) begin
            n_status = gss_pkg::STATUS_PARTIAL;
        end else begin
            n_status = gss_pkg::STATUS_OK;
        end
    end

    // search registers
    logic [CW-1:0]  r_n;
    logic [FW-1:0]  r_f;
    logic [SIW-1:0] r_j;
    logic [SIW-1:0] r_i;
    logic [VW-1:0]  r_thr;
    logic [DRW-1:0] r_drain;
    logic [CW-1:0]  r_nl;
    logic [CW-1:0]  r_nr;
    logic [LW-1:0]  r_c;
    logic [CW-1:0]  r_l;
    logic [CW-1:0]  r_r;
    logic [2*CW-1:0] r_lsq;
    logic [2*CW-1:0] r_rsq;
    logic [IW-1:0]  r_sum;
    logic           r_have;
    logic [FW-1:0]  r_best_f;
    logic [VW-1:0]  r_best_t;
    logic [IW-1:0]  r_best_i;
    logic [1:0]     r_status;
    logic           r_rd_valid;
    logic [IW-1:0]  imp;

    logic last_i, last_j, last_f, last_c;
    assign last_i = (int'(r_i) == int'(r_n) - 1);
    assign last_j = (int'(r_j) == int'(r_n) - 1);
    assign last_f = (int'(r_f) == int'(nf_eff) - 1);
    assign last_c = (int'(r_c) == MAX_CLASSES - 1);
    assign imp    = IW'({r_n, {gss_pkg::FRAC_BITS{1'b0}}}) - r_sum;

    // divider
    logic          div_start;
    logic          div_busy;
    logic          div_done;
    logic [NW-1:0] div_num;
    logic [CW-1:0] div_den;
    logic [NW-1:0] div_quot;

    gss_div #(
        .NW(NW),
        .DW(CW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_busy (div_busy),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gss_pkg::S_LOAD: begin
                if (in_accept && i_in.last_item) begin
                    n_state = (n_sample_cnt == '0) ? gss_pkg::S_OUT : gss_pkg::S_THR_RD;
                end
            end
            gss_pkg::S_THR_RD:    n_state = gss_pkg::S_THR_CAP;
            gss_pkg::S_THR_CAP:   n_state = gss_pkg::S_SWEEP;
            gss_pkg::S_SWEEP:     if (last_i) n_state = gss_pkg::S_DRAIN;
            gss_pkg::S_DRAIN: begin
                if (int'(r_drain) == MAX_CLASSES + 1) n_state = gss_pkg::S_EV_LOAD;
            end
            gss_pkg::S_EV_LOAD:   n_state = gss_pkg::S_EV_MUL;
            gss_pkg::S_EV_MUL:    n_state = gss_pkg::S_DIVL_GO;
            gss_pkg::S_DIVL_GO: begin
                n_state = (r_nl != '0) ? gss_pkg::S_DIVL_WAIT : gss_pkg::S_DIVR_GO;
            end
            gss_pkg::S_DIVL_WAIT: if (div_done) n_state = gss_pkg::S_DIVR_GO;
            gss_pkg::S_DIVR_GO: begin
                n_state = (r_nr != '0) ? gss_pkg::S_DIVR_WAIT : gss_pkg::S_EV_NEXT;
            end
            gss_pkg::S_DIVR_WAIT: if (div_done) n_state = gss_pkg::S_EV_NEXT;
            gss_pkg::S_EV_NEXT: begin
                n_state = last_c ? gss_pkg::S_CMP : gss_pkg::S_EV_LOAD;
            end
            gss_pkg::S_CMP: begin
                n_state = (last_j && last_f) ? gss_pkg::S_OUT : gss_pkg::S_THR_RD;
            end
            gss_pkg::S_OUT:       if (out_xfer) n_state = gss_pkg::S_LOAD;
            default:              n_state = gss_pkg::S_LOAD;
        endcase
    end

    // state outputs
    logic          cell_shift;
    logic          mem_we;
    logic          lab_we;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign wr_addr = AW'(int'(r_sample_cnt[SIW-1:0]) * MAX_FEATURES + int'(r_pos));

    always_comb begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cell_shift = 1'b0;
        div_start  = 1'b0;
        div_num    = {r_lsq, {gss_pkg::FRAC_BITS{1'b0}}};
        div_den    = r_nl;
        rd_addr    = AW'(int'(r_i) * MAX_FEATURES + int'(r_f));
        case (r_state)
            gss_pkg::S_LOAD:    in_ready = 1'b1;
            gss_pkg::S_THR_RD:  rd_addr = AW'(int'(r_j) * MAX_FEATURES + int'(r_f));
            gss_pkg::S_EV_LOAD: cell_shift = 1'b1;
            gss_pkg::S_DIVL_GO: div_start = (r_nl != '0);
            gss_pkg::S_DIVR_GO: begin
                div_start = (r_nr != '0);
                div_num   = {r_rsq, {gss_pkg::FRAC_BITS{1'b0}}};
                div_den   = r_nr;
            end
            gss_pkg::S_OUT:     out_valid = 1'b1;
            default: ;
        endcase
        mem_we = in_accept && !full;
        lab_we = mem_we && (r_pos == '0);
    end

    // sample stores
    logic [VW-1:0] feature_mem [MAX_SAMPLES * MAX_FEATURES];
    logic [LW-1:0] label_mem [MAX_SAMPLES];
    logic [VW-1:0] r_rd_value;
    logic [LW-1:0] r_rd_label;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            feature_mem[wr_addr] <= i_in.feature_value;
        end
        r_rd_value <= feature_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (lab_we) begin
            label_mem[r_sample_cnt[SIW-1:0]] <= i_in.class_label;
        end
        r_rd_label <= label_mem[r_i];
    end

    // class cell chain
    gss_pkg::t_tok tok [MAX_CLASSES + 1];
    logic [LW-1:0] tok_label [MAX_CLASSES + 1];
    logic [CW-1:0] cnt_left [MAX_CLASSES + 1];
    logic [CW-1:0] cnt_right [MAX_CLASSES + 1];

    assign tok[0].valid  = r_rd_valid;
    assign tok[0].right  = $signed(r_rd_value) > $signed(r_thr);
    assign tok_label[0]  = r_rd_label;
    assign cnt_left[MAX_CLASSES]  = '0;
    assign cnt_right[MAX_CLASSES] = '0;

    for (genvar k = 0; k < MAX_CLASSES; k++) begin : g_cell
        gss_cell #(
            .CLASS_ID(k),
            .LW(LW),
            .CW(CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (k < int'(nc_eff)),
            .i_shift     (cell_shift),
            .i_tok       (tok[k]),
            .i_tok_label (tok_label[k]),
            .o_tok       (tok[k+1]),
            .o_tok_label (tok_label[k+1]),
            .i_next_left (cnt_left[k+1]),
            .i_next_right(cnt_right[k+1]),
            .o_left      (cnt_left[k]),
            .o_right     (cnt_right[k])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gss_pkg::S_LOAD;
            r_sample_cnt <= '0;
            r_pos        <= '0;
            r_dropped    <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_n          <= '0;
            r_f          <= '0;
            r_j          <= '0;
            r_i          <= '0;
            r_c          <= '0;
            r_drain      <= '0;
            r_have       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= (r_state == gss_pkg::S_SWEEP);
            case (r_state)
                gss_pkg::S_LOAD: begin
                    if (in_accept) begin
                        if (i_in.last_item) begin
                            r_n          <= n_sample_cnt;
                            r_sample_cnt <= '0;
                            r_pos        <= '0;
                            r_dropped    <= 1'b0;
                            r_f          <= '0;
                            r_j          <= '0;
                            r_have       <= 1'b0;
                        end else begin
                            r_sample_cnt <= n_sample_cnt;
                            r_pos        <= n_pos;
                            r_dropped    <= n_dropped;
                        end
                    end
                end
                gss_pkg::S_THR_RD: begin
                    r_i     <= '0;
                    r_c     <= '0;
                    r_drain <= '0;
                end
                gss_pkg::S_SWEEP:   r_i <= r_i + 1'b1;
                gss_pkg::S_DRAIN:   r_drain <= r_drain + 1'b1;
                gss_pkg::S_EV_NEXT: r_c <= r_c + 1'b1;
                gss_pkg::S_CMP: begin
                    r_have <= 1'b1;
                    if (last_j) begin
                        r_j <= '0;
                        r_f <= r_f + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            gss_pkg::S_LOAD: begin
                if (in_accept && i_in.last_item) begin
                    r_status <= n_status;
                    r_best_f <= '0;
                    r_best_t <= '0;
                    r_best_i <= '0;
                end
            end
            gss_pkg::S_THR_RD: begin
                r_nl  <= '0;
                r_nr  <= '0;
                r_sum <= '0;
            end
            gss_pkg::S_THR_CAP: r_thr <= r_rd_value;
            gss_pkg::S_EV_LOAD: begin
                r_l <= cnt_left[0];
                r_r <= cnt_right[0];
            end
            gss_pkg::S_EV_MUL: begin
                r_lsq <= r_l * r_l;
                r_rsq <= r_r * r_r;
            end
            gss_pkg::S_DIVL_WAIT: if (div_done) r_sum <= r_sum + div_quot[IW-1:0];
            gss_pkg::S_DIVR_WAIT: if (div_done) r_sum <= r_sum + div_quot[IW-1:0];
            gss_pkg::S_CMP: begin
                if (!r_have || imp < r_best_i) begin
                    r_best_i <= imp;
                    r_best_f <= r_f;
                    r_best_t <= r_thr;
                end
            end
            default: ;
        endcase
        // side totals follow the tokens entering the chain
        if (r_rd_valid) begin
            if (tok[0].right) begin
                r_nr <= r_nr + 1'b1;
            end else begin
                r_nl <= r_nl + 1'b1;
            end
        end
    end

    // result channel
    assign i_in.ready           = in_ready;
    assign o_out.valid          = out_valid;
    assign o_out.best_feature   = r_best_f;
    assign o_out.best_threshold = r_best_t;
    assign o_out.best_impurity  = r_best_i;
    assign o_out.sample_total   = r_n;
    assign o_out.status         = r_status;

    // checks
    `GSS_NEVER(a_load_and_result, i_clk, i_rst_n, in_ready && out_valid)
    `GSS_NEVER(a_div_restart, i_clk, i_rst_n, div_start && div_busy)
    `GSS_ASSERT(a_empty_total, i_clk, i_rst_n, (out_valid && r_status == gss_pkg::STATUS_EMPTY) |-> (r_n == '0))
    `GSS_ASSERT(a_chain_clear, i_clk, i_rst_n, (r_state == gss_pkg::S_CMP) |-> (cnt_left[0] == '0 && cnt_right[0] == '0))
endmodule

// ===== verif/testbench.sv =====
// self-checking testbench of the gini split search: node loading, best split and status
`timescale 1ns / 1ps
module testbench;
    localparam int NSAMP     = 1024;
    localparam int NFEAT     = 16;
    localparam int NCLASS    = 16;
    localparam int STALL_MAX = 12000000;

    typedef struct {
        logic [3:0]  feature;
        logic [31:0] threshold;
        logic [26:0] impurity;
        logic [10:0] total;
        logic [1:0]  status;
    } t_split;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [gss_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [gss_pkg::CFG_W-1:0] i_cfg_data;

    gss_in_if  #(.VW(32), .LW(4)) in_if ();
    gss_out_if #(.VW(32), .FW(4), .IW(27), .CW(11)) out_if ();

    gini_split_search uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // predictor state
    logic [31:0] value_mem [NSAMP][NFEAT];
    logic [3:0]  label_mem [NSAMP];
    int          loaded_samples;
    int          feat_pos;
    bit          lost_items;
    logic [4:0]  feat_cfg;
    logic [4:0]  class_cfg;

    t_split expected_splits[$];
    int     errors;
    bit     quiet;
    int     items_sent;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int active_features();
        if (feat_cfg == 0) return 1;
        if (feat_cfg > NFEAT) return NFEAT;
        return int'(feat_cfg);
    endfunction

    function automatic int active_classes();
        if (class_cfg > NCLASS) return NCLASS;
        return int'(class_cfg);
    endfunction

    // weighted gini impurity of one candidate, 16 fraction bits
    function automatic logic [63:0] split_impurity(int feat, logic [31:0] thr, int n, int nc);
        int lc [NCLASS];
        int rc [NCLASS];
        int nl, nr;
        logic [63:0] acc;
        logic [63:0] sq;
        nl = 0;
        nr = 0;
        acc = 0;
        for (int c = 0; c < NCLASS; c++) begin
            lc[c] = 0;
            rc[c] = 0;
        end
        for (int i = 0; i < n; i++) begin
            if ($signed(value_mem[i][feat]) > $signed(thr)) begin
                nr++;
                if (label_mem[i] < nc) rc[label_mem[i]]++;
            end else begin
                nl++;
                if (label_mem[i] < nc) lc[label_mem[i]]++;
            end
        end
        for (int c = 0; c < nc; c++) begin
            if (nl != 0) begin
                sq = 64'(lc[c]) * 64'(lc[c]);
                acc += (sq << 16) / 64'(nl);
            end
            if (nr != 0) begin
                sq = 64'(rc[c]) * 64'(rc[c]);
                acc += (sq << 16) / 64'(nr);
            end
        end
        return (64'(n) << 16) - acc;
    endfunction

    // load one item into the predictor, queue the split on the last item
    task automatic predict_item(input logic [31:0] v, input logic [3:0] lab, input bit last);
        int nf, n;
        logic [63:0] g, best_g;
        bit have;
        t_split r;
        nf = active_features();
        if (loaded_samples < NSAMP) begin
            if (feat_pos == 0) label_mem[loaded_samples] = lab;
            value_mem[loaded_samples][feat_pos % NFEAT] = v;
            if (feat_pos + 1 >= nf) begin
                feat_pos = 0;
                loaded_samples++;
            end else begin
                feat_pos++;
            end
        end else begin
            lost_items = 1'b1;
        end
        if (last) begin
            n = loaded_samples;
            r.feature = 0;
            r.threshold = 0;
            best_g = 0;
            have = 0;
            if (n == 0) r.status = gss_pkg::STATUS_EMPTY;
            else if (lost_items) r.status = gss_pkg::STATUS_DROPPED;
            else if (feat_pos != 0) r.status = gss_pkg::STATUS_PARTIAL;
            else r.status = gss_pkg::STATUS_OK;
            if (n != 0) begin
                for (int f = 0; f < nf; f++) begin
                    for (int j = 0; j < n; j++) begin
                        g = split_impurity(f, value_mem[j][f], n, active_classes());
                        if (!have || g < best_g) begin
                            have = 1;
                            best_g = g;
                            r.feature = f[3:0];
                            r.threshold = value_mem[j][f];
                        end
                    end
                end
            end
            r.impurity = best_g[26:0];
            r.total = n[10:0];
            expected_splits.push_back(r);
            loaded_samples = 0;
            feat_pos = 0;
            lost_items = 0;
        end
    endtask

    // one item transfer, entered and left at a falling edge with valid still high
    task automatic send_item(input logic [31:0] v, input logic [3:0] lab, input bit last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.feature_value = v;
        in_if.class_label = lab;
        in_if.last_item = last;
        do @(posedge i_clk); while (!in_if.ready);
        predict_item(v, lab, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    // wait for every queued split, then let the block settle
    task automatic drain_splits();
        in_if.valid = 1'b0;
        while (expected_splits.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [gss_pkg::CFG_IDX_W-1:0] idx, input logic [4:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        if (idx == gss_pkg::CFG_FEATURE_COUNT) feat_cfg = data;
        else class_cfg = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 6)) - 3) << 16;
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            3: return 32'($signed($urandom_range(0, 4)) - 2);
            default: return {{16{1'b0}}, 16'($urandom_range(0, 3))} << 14;
        endcase
    endfunction

    // one node: samples complete samples plus extra trailing items
    task automatic send_node(input int samples, input int extra);
        int nf, total;
        nf = active_features();
        total = samples * nf + extra;
        for (int k = 0; k < total; k++)
            send_item(pick_value(), 4'($urandom_range(0, 15)), k == total - 1);
        drain_splits();
    endtask

    task automatic test_reset_defaults();
        send_item(32'h0001_0000, 4'd0, 0);
        send_item(32'h0002_0000, 4'd1, 0);
        send_item(32'h0002_0000, 4'd1, 1);
        drain_splits();
    endtask

    task automatic test_field_extremes();
        write_reg(gss_pkg::CFG_FEATURE_COUNT, 5'd2);
        write_reg(gss_pkg::CFG_CLASS_COUNT, 5'd16);
        send_item(32'h8000_0000, 4'd0, 0);
        send_item(32'h7fff_ffff, 4'd15, 0);
        send_item(32'h7fff_ffff, 4'd15, 0);
        send_item(32'h8000_0000, 4'd0, 0);
        send_item(32'hffff_ffff, 4'd5, 0);
        send_item(32'h0000_0000, 4'd10, 1);
        drain_splits();
    endtask

    task automatic test_config_extremes();
        // feature count zero acts as one, class count zero counts nothing
        write_reg(gss_pkg::CFG_FEATURE_COUNT, 5'd0);
        write_reg(gss_pkg::CFG_CLASS_COUNT, 5'd0);
        send_node(3, 0);
        // counts above the maximum saturate
        write_reg(gss_pkg::CFG_FEATURE_COUNT, 5'd31);
        write_reg(gss_pkg::CFG_CLASS_COUNT, 5'd31);
        send_node(1, 0);
        write_reg(gss_pkg::CFG_FEATURE_COUNT, 5'd17);
        write_reg(gss_pkg::CFG_CLASS_COUNT, 5'd17);
        send_node(1, 0);
    endtask

    task automatic test_empty_and_partial();
        // empty set: two items of an unfinished sample
        write_reg(gss_pkg::CFG_FEATURE_COUNT, 5'd3);
        write_reg(gss_pkg::CFG_CLASS_COUNT, 5'd1);
        send_node(0, 2);
        // incomplete last sample
        write_reg(gss_pkg::CFG_CLASS_COUNT, 5'd3);
        send_node(2, 1);
    endtask

    task automatic test_store_full();
        // one feature, one class keeps the full search short
        write_reg(gss_pkg::CFG_FEATURE_COUNT, 5'd1);
        write_reg(gss_pkg::CFG_CLASS_COUNT, 5'd1);
        for (int k = 0; k < NSAMP + 2; k++)
            send_item(pick_value(), 4'($urandom_range(0, 1)), k == NSAMP + 1);
        drain_splits();
    endtask

    task automatic test_random_nodes(input int item_goal);
        int nf, samples, extra;
        while (items_sent < item_goal) begin
            if ($urandom_range(0, 9) == 0) nf = $urandom_range(0, 31);
            else nf = $urandom_range(1, 4);
            write_reg(gss_pkg::CFG_FEATURE_COUNT, 5'(nf));
            if ($urandom_range(0, 9) == 0)
                write_reg(gss_pkg::CFG_CLASS_COUNT, 5'($urandom_range(0, 31)));
            else write_reg(gss_pkg::CFG_CLASS_COUNT, 5'($urandom_range(1, 4)));
            if (active_features() > 4) samples = $urandom_range(1, 2);
            else samples = $urandom_range(1, 6);
            extra = 0;
            if ($urandom_range(0, 7) == 0 && active_features() > 1)
                extra = $urandom_range(1, active_features() - 1);
            if ($urandom_range(0, 19) == 0) samples = 0;
            if (samples == 0 && extra == 0) extra = active_features() > 1 ? 1 : 0;
            if (samples == 0 && extra == 0) samples = 1;
            send_node(samples, extra);
        end
    endtask

    // result side: random stalls
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                out_if.ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
        end
    end

    // compare each split transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_split e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_splits.size() == 0) begin
                $error("unexpected split transfer");
                errors++;
            end else begin
                e = expected_splits.pop_front();
                if (out_if.best_feature !== e.feature) begin
                    $error("best_feature expected %0d actual %0d", e.feature, out_if.best_feature);
                    errors++;
                end
                if (out_if.best_threshold !== e.threshold) begin
                    $error("best_threshold expected %h actual %h", e.threshold,
                           out_if.best_threshold);
                    errors++;
                end
                if (out_if.best_impurity !== e.impurity) begin
                    $error("best_impurity expected %0d actual %0d", e.impurity,
                           out_if.best_impurity);
                    errors++;
                end
                if (out_if.sample_total !== e.total) begin
                    $error("sample_total expected %0d actual %0d", e.total, out_if.sample_total);
                    errors++;
                end
                if (out_if.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, out_if.status);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_MAX) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = gss_pkg::CFG_FEATURE_COUNT;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.feature_value = '0;
        in_if.class_label = '0;
        in_if.last_item = 1'b0;
        errors = 0;
        quiet = 0;
        items_sent = 0;
        loaded_samples = 0;
        feat_pos = 0;
        lost_items = 0;
        feat_cfg = gss_pkg::FEATURE_COUNT_RST;
        class_cfg = gss_pkg::CLASS_COUNT_RST;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_field_extremes();
        test_config_extremes();
        test_empty_and_partial();
        test_store_full();
        test_random_nodes(1150);
        quiet = 1;
        test_random_nodes(1300);

        if (errors == 0 && expected_splits.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/gss_pkg.sv
src/gss_if.sv
src/gss_cell.sv
src/gss_div.sv
src/gini_split_search.sv
verif/testbench.sv
